FILE: hw/rtl/mte_pkg.sv
// ----------------------------------------------------------------------------
// mte_pkg
// Shared types and constants of the timer slot expiry engine.
// ----------------------------------------------------------------------------
package mte_pkg;

  localparam int NUM_SLOTS_DEF = 16;
  localparam int TIME_BITS_DEF = 32;

  localparam int MODE_W   = 3;
  localparam int SLOT_W   = 4;
  localparam int PERIOD_W = 32;
  localparam int REM_W    = 31;
  localparam int CNT_W    = 5;

  typedef enum logic [MODE_W-1:0] {
    MODE_CONFIG  = 3'd0,
    MODE_START   = 3'd1,
    MODE_STOP    = 3'd2,
    MODE_RESTART = 3'd3,
    MODE_CHG_PER = 3'd4,
    MODE_DELETE  = 3'd5,
    MODE_QUERY   = 3'd6,
    MODE_TICK    = 3'd7
  } mode_t;

  // command broadcast to every cell
  typedef struct packed {
    logic                wr;
    logic                rd;
    mode_t               mode;
    logic [SLOT_W-1:0]   slot;
    logic [PERIOD_W-1:0] period;
    logic                reload;
  } cmd_t;

  // per-cell events during a tick
  typedef struct packed {
    logic hit;   // slot expired on this scan step
    logic drop;  // expired slot was one-shot and went inactive
    logic emit;  // cell drives the result bus
  } ev_t;

endpackage

FILE: hw/rtl/mte_cell.sv
// ----------------------------------------------------------------------------
// mte_cell
// One timer slot: period, type, expiry and active mark, with scan and emit
// tokens passed on to the next cell.
// ----------------------------------------------------------------------------
module mte_cell #(
  parameter int IDX       = 0,
  parameter int TIME_BITS = mte_pkg::TIME_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [TIME_BITS-1:0] now,
  input  mte_pkg::cmd_t        cmd,
  input  logic                 scan_in,
  output logic                 scan_out,
  input  logic                 emit_in,
  output logic                 emit_out,
  output mte_pkg::ev_t         ev,
  output logic                 rd_act,
  output logic [TIME_BITS-1:0] rd_exp
);

  logic [TIME_BITS-1:0] exp_r, exp_nxt;
  logic [TIME_BITS-1:0] per_r, per_nxt;
  logic                 rel_r, rel_nxt;
  logic                 act_r, act_nxt;
  logic                 hit_r, hit_nxt;
  logic                 scan_r, emit_r;
  logic                 match;
  logic                 due;
  logic                 sel;
  logic [TIME_BITS-1:0] diff;
  logic [TIME_BITS-1:0] new_per;

  assign match   = (32'(cmd.slot) == 32'(IDX));
  assign diff    = now - exp_r;
  assign due     = scan_in && act_r && !diff[TIME_BITS-1];
  assign new_per = cmd.period[TIME_BITS-1:0];

  assign ev.hit  = due;
  assign ev.drop = due && !rel_r;
  assign ev.emit = emit_in && hit_r;

  assign sel    = ev.emit || (cmd.rd && match);
  assign rd_act = sel && act_r;
  assign rd_exp = sel ? exp_r : '0;

  assign scan_out = scan_r;
  assign emit_out = emit_r;

  always_comb begin
    exp_nxt = exp_r;
    per_nxt = per_r;
    rel_nxt = rel_r;
    act_nxt = act_r;
    hit_nxt = hit_r;
    if (cmd.wr && match) begin
      unique case (cmd.mode)
        mte_pkg::MODE_CONFIG: begin
          if (cmd.period != '0) begin
            act_nxt = 1'b0;
            exp_nxt = '0;
            per_nxt = new_per;
            rel_nxt = cmd.reload;
          end
        end
        mte_pkg::MODE_START, mte_pkg::MODE_RESTART: begin
          exp_nxt = now + per_r;
          act_nxt = 1'b1;
        end
        mte_pkg::MODE_STOP: act_nxt = 1'b0;
        mte_pkg::MODE_CHG_PER: begin
          if (cmd.period != '0) begin
            per_nxt = new_per;
            if (act_r) exp_nxt = now + new_per;
          end
        end
        mte_pkg::MODE_DELETE: begin
          act_nxt = 1'b0;
          exp_nxt = '0;
          per_nxt = '0;
          rel_nxt = 1'b0;
        end
        default: ;
      endcase
    end
    if (due) begin
      hit_nxt = 1'b1;
      act_nxt = rel_r;
      // re-arm auto-reload slots one period past now
      if (rel_r) exp_nxt = now + per_r;
    end
    if (ev.emit) hit_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      per_r  <= '0;
      rel_r  <= 1'b0;
      act_r  <= 1'b0;
      hit_r  <= 1'b0;
      scan_r <= 1'b0;
      emit_r <= 1'b0;
    end else begin
      per_r  <= per_nxt;
      rel_r  <= rel_nxt;
      act_r  <= act_nxt;
      hit_r  <= hit_nxt;
      scan_r <= scan_in;
      emit_r <= emit_in;
    end
  end

  always_ff @(posedge clk) begin
    exp_r <= exp_nxt;
  end

endmodule

FILE: hw/rtl/mte_chain.sv
// ----------------------------------------------------------------------------
// mte_chain
// Row of timer cells with scan and emit token lines and the shared read bus.
// ----------------------------------------------------------------------------
module mte_chain #(
  parameter int NUM_SLOTS = mte_pkg::NUM_SLOTS_DEF,
  parameter int TIME_BITS = mte_pkg::TIME_BITS_DEF,
  parameter int IW        = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [TIME_BITS-1:0] now,
  input  mte_pkg::cmd_t        cmd,
  input  logic                 scan_inj,
  input  logic                 emit_inj,
  output logic                 scan_done,
  output logic                 emit_done,
  output mte_pkg::ev_t         ev,
  output logic                 rd_act,
  output logic [TIME_BITS-1:0] rd_exp,
  output logic [IW-1:0]        emit_idx
);

  logic                 scan_tok [NUM_SLOTS+1];
  logic                 emit_tok [NUM_SLOTS+1];
  mte_pkg::ev_t         cell_ev  [NUM_SLOTS];
  logic                 cell_act [NUM_SLOTS];
  logic [TIME_BITS-1:0] cell_exp [NUM_SLOTS];

  assign scan_tok[0] = scan_inj;
  assign emit_tok[0] = emit_inj;
  assign scan_done   = scan_tok[NUM_SLOTS];
  assign emit_done   = emit_tok[NUM_SLOTS];

  for (genvar i = 0; i < NUM_SLOTS; i++) begin : g_cell
    mte_cell #(
      .IDX       (i),
      .TIME_BITS (TIME_BITS)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .now      (now),
      .cmd      (cmd),
      .scan_in  (scan_tok[i]),
      .scan_out (scan_tok[i+1]),
      .emit_in  (emit_tok[i]),
      .emit_out (emit_tok[i+1]),
      .ev       (cell_ev[i]),
      .rd_act   (cell_act[i]),
      .rd_exp   (cell_exp[i])
    );
  end

  // at most one cell is selected at a time: merge by OR
  always_comb begin
    ev       = '0;
    rd_act   = 1'b0;
    rd_exp   = '0;
    emit_idx = '0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      ev     = ev | cell_ev[i];
      rd_act = rd_act | cell_act[i];
      rd_exp = rd_exp | cell_exp[i];
      if (cell_ev[i].emit) emit_idx = emit_idx | IW'(i);
    end
  end

endmodule

FILE: hw/rtl/multi_timer_expiry_engine.sv
// ----------------------------------------------------------------------------
// multi_timer_expiry_engine
// Table of one-shot and auto-reload timer slots with a wrapping time base.
// ----------------------------------------------------------------------------
// Usage:
//   A request is taken on a rising edge with start high and busy low. in_mode
//   selects configure, start, stop, restart, change period, delete, query or
//   tick; in_slot, in_period and in_auto_reload qualify slot commands.
//   Each result shows on the out_ ports for one cycle with out_strobe high.
//   A slot command passes through the command and response states, and its
//   single result (out_last set) reaches the ports as busy falls.
//   A tick advances the time and then walks a scan token down the row of
//   cells, one slot per cycle, updating expired slots; a second token walks
//   the row again and each expired slot drives one result in ascending slot
//   order. A tick keeps busy high through both passes over the cell row. A
//   tick with no expiry gives no result.
//   Reset clears the time, all periods, types and active marks.
//   Results cannot be held off by the receiver; it must take each strobe.
// ----------------------------------------------------------------------------
module multi_timer_expiry_engine #(
  parameter int NUM_SLOTS = mte_pkg::NUM_SLOTS_DEF,
  parameter int TIME_BITS = mte_pkg::TIME_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [mte_pkg::MODE_W-1:0]   in_mode,
  input  logic [mte_pkg::SLOT_W-1:0]   in_slot,
  input  logic [mte_pkg::PERIOD_W-1:0] in_period,
  input  logic                         in_auto_reload,
  output logic                         out_strobe,
  output logic                         out_status,
  output logic [mte_pkg::SLOT_W-1:0]   out_slot_out,
  output logic                         out_expired,
  output logic                         out_is_active,
  output logic [mte_pkg::REM_W-1:0]    out_remaining,
  output logic [mte_pkg::CNT_W-1:0]    out_active_count,
  output logic                         out_last
);

  localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CW = $clog2(NUM_SLOTS + 1);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_CMD  = 5'b00010,
    ST_RESP = 5'b00100,
    ST_SCAN = 5'b01000,
    ST_EMIT = 5'b10000
  } state_t;

  state_t                       state_r, state_nxt;
  logic [TIME_BITS-1:0]         now_r;
  logic [CW-1:0]                cnt_r, cnt_nxt;
  logic [CW-1:0]                hits_r;
  logic                         scan_inj_r, emit_inj_r;
  mte_pkg::mode_t               mode_r;
  logic [mte_pkg::SLOT_W-1:0]   slot_r;
  logic [mte_pkg::PERIOD_W-1:0] period_r;
  logic                         reload_r;

  mte_pkg::cmd_t        cmd;
  mte_pkg::ev_t         ev;
  logic                 scan_done, emit_done;
  logic                 rd_act;
  logic [TIME_BITS-1:0] rd_exp;
  logic [IW-1:0]        emit_idx;
  logic                 accept;
  logic                 in_range;
  logic                 zero_per;
  logic                 new_act;
  logic [TIME_BITS-1:0] left;
  logic [31:0]          left_ext;
  logic                 left_ok;

  logic                         out_strobe_r;
  logic                         out_status_r;
  logic [mte_pkg::SLOT_W-1:0]   out_slot_r;
  logic                         out_expired_r;
  logic                         out_act_r;
  logic [mte_pkg::REM_W-1:0]    out_rem_r;
  logic [mte_pkg::CNT_W-1:0]    out_cnt_r;
  logic                         out_last_r;

  assign busy     = (state_r != ST_IDLE);
  assign accept   = start && !busy;
  assign in_range = (32'(slot_r) < 32'(NUM_SLOTS));
  assign zero_per = (period_r == '0);

  assign cmd.wr     = (state_r == ST_CMD) && in_range;
  assign cmd.rd     = (state_r == ST_CMD) || (state_r == ST_RESP);
  assign cmd.mode   = mode_r;
  assign cmd.slot   = slot_r;
  assign cmd.period = period_r;
  assign cmd.reload = reload_r;

  mte_chain #(
    .NUM_SLOTS (NUM_SLOTS),
    .TIME_BITS (TIME_BITS),
    .IW        (IW)
  ) u_chain (
    .clk       (clk),
    .rst_n     (rst_n),
    .now       (now_r),
    .cmd       (cmd),
    .scan_inj  (scan_inj_r),
    .emit_inj  (emit_inj_r),
    .scan_done (scan_done),
    .emit_done (emit_done),
    .ev        (ev),
    .rd_act    (rd_act),
    .rd_exp    (rd_exp),
    .emit_idx  (emit_idx)
  );

  // active mark of the addressed slot after the command
  always_comb begin
    new_act = rd_act;
    unique case (mode_r)
      mte_pkg::MODE_CONFIG:  if (!zero_per) new_act = 1'b0;
      mte_pkg::MODE_START,
      mte_pkg::MODE_RESTART: new_act = 1'b1;
      mte_pkg::MODE_STOP,
      mte_pkg::MODE_DELETE:  new_act = 1'b0;
      default:               new_act = rd_act;
    endcase
    if (!in_range) new_act = 1'b0;
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (state_r == ST_CMD) begin
      cnt_nxt = cnt_r - CW'(rd_act) + CW'(new_act);
    end else if (ev.drop) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = (mte_pkg::mode_t'(in_mode) == mte_pkg::MODE_TICK) ? ST_SCAN : ST_CMD;
        end
      end
      ST_CMD:  state_nxt = ST_RESP;
      ST_RESP: state_nxt = ST_IDLE;
      ST_SCAN: if (scan_done) state_nxt = ST_EMIT;
      ST_EMIT: if (emit_done) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      now_r      <= '0;
      cnt_r      <= '0;
      hits_r     <= '0;
      scan_inj_r <= 1'b0;
      emit_inj_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      cnt_r      <= cnt_nxt;
      scan_inj_r <= 1'b0;
      emit_inj_r <= 1'b0;
      if (accept && mte_pkg::mode_t'(in_mode) == mte_pkg::MODE_TICK) begin
        now_r      <= now_r + TIME_BITS'(1);
        scan_inj_r <= 1'b1;
      end
      if (state_r == ST_SCAN && scan_done) emit_inj_r <= 1'b1;
      if (ev.hit) begin
        hits_r <= hits_r + CW'(1);
      end else if (ev.emit) begin
        hits_r <= hits_r - CW'(1);
      end
    end
  end

  // hold the request fields for the command cycles
  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r   <= mte_pkg::mode_t'(in_mode);
      slot_r   <= in_slot;
      period_r <= in_period;
      reload_r <= in_auto_reload;
    end
  end

  // ticks left: zero when inactive, due now or past due
  assign left     = rd_exp - now_r;
  assign left_ok  = rd_act && (left != '0) && !left[TIME_BITS-1];
  assign left_ext = 32'(left);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= (state_r == ST_RESP) || ev.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_RESP) begin
      out_status_r  <= !in_range ||
                       ((mode_r == mte_pkg::MODE_CONFIG || mode_r == mte_pkg::MODE_CHG_PER)
                        && zero_per);
      out_slot_r    <= slot_r;
      out_expired_r <= 1'b0;
      out_act_r     <= rd_act;
      out_rem_r     <= left_ok ? left_ext[mte_pkg::REM_W-1:0] : '0;
      out_cnt_r     <= mte_pkg::CNT_W'(cnt_r);
      out_last_r    <= 1'b1;
    end else if (ev.emit) begin
      out_status_r  <= 1'b0;
      out_slot_r    <= mte_pkg::SLOT_W'(emit_idx);
      out_expired_r <= 1'b1;
      out_act_r     <= rd_act;
      out_rem_r     <= left_ok ? left_ext[mte_pkg::REM_W-1:0] : '0;
      out_cnt_r     <= mte_pkg::CNT_W'(cnt_r);
      out_last_r    <= (hits_r == CW'(1));
    end
  end

  assign out_strobe       = out_strobe_r;
  assign out_status       = out_status_r;
  assign out_slot_out     = out_slot_r;
  assign out_expired      = out_expired_r;
  assign out_is_active    = out_act_r;
  assign out_remaining    = out_rem_r;
  assign out_active_count = out_cnt_r;
  assign out_last         = out_last_r;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(NUM_SLOTS))
    else $error("active count exceeds slot count");

  a_idle_no_hits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> (hits_r == '0))
    else $error("expired slots left unreported");

  a_emit_in_emit: assert property (@(posedge clk) disable iff (!rst_n)
    ev.emit |-> (state_r == ST_EMIT))
    else $error("result driven outside the emit pass");

  a_hit_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    ev.hit |-> (state_r == ST_SCAN))
    else $error("slot expired outside the scan pass");

  a_resp_last: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RESP) |=> (out_strobe && out_last && !out_expired))
    else $error("command result missing");
`endif

endmodule

FILE: test/multi_timer_expiry_engine_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// multi_timer_expiry_engine_tb
// Self-checking bench for the timer slot expiry engine. A short directed
// sequence hits the corner cases: zero period, start of an unconfigured slot,
// reconfigure while active, periods with the top bit set and a quiet tick.
// Random phases with different sender gap rates follow. Every accepted request
// runs through a slot table model. Each result strobe is checked against the
// oldest predicted result, field by field.
// ----------------------------------------------------------------------------
module multi_timer_expiry_engine_tb;

  localparam int SLOTS       = mte_pkg::NUM_SLOTS_DEF;
  localparam int SCAN_CYCLES = 2 * SLOTS + 2;

  typedef struct packed {
    logic                       status;
    logic [mte_pkg::SLOT_W-1:0] slot;
    logic                       expired;
    logic                       is_active;
    logic [mte_pkg::REM_W-1:0]  remaining;
    logic [mte_pkg::CNT_W-1:0]  count;
    logic                       last;
  } timer_result_t;

  class expiry_scoreboard;
    logic [mte_pkg::PERIOD_W-1:0] now;
    logic [mte_pkg::PERIOD_W-1:0] expiry [SLOTS];
    logic [mte_pkg::PERIOD_W-1:0] period [SLOTS];
    bit                           reload [SLOTS];
    bit                           active [SLOTS];
    timer_result_t                due [$];
    int errors;
    int requests;
    int ticks;
    int results;
    int expiries;
    int max_burst;

    function new();
      now = '0;
      foreach (expiry[i]) begin
        expiry[i] = '0;
        period[i] = '0;
        reload[i] = 1'b0;
        active[i] = 1'b0;
      end
      errors    = 0;
      requests  = 0;
      ticks     = 0;
      results   = 0;
      expiries  = 0;
      max_burst = 0;
    endfunction

    function int active_total();
      int n;
      n = 0;
      foreach (active[i]) n += int'(active[i]);
      return n;
    endfunction

    function logic [mte_pkg::REM_W-1:0] ticks_left(int i);
      logic [mte_pkg::PERIOD_W-1:0] d;
      if (!active[i]) return '0;
      d = expiry[i] - now;
      // due now or in the past on the wrapping time base
      if (d == '0 || d[mte_pkg::PERIOD_W-1]) return '0;
      return d[mte_pkg::REM_W-1:0];
    endfunction

    function void arm(int i);
      expiry[i] = now + period[i];
      active[i] = 1'b1;
    endfunction

    function timer_result_t make_result(logic status, int i, logic expired, logic last_flag,
                                        int cnt);
      timer_result_t r;
      r.status    = status;
      r.slot      = i[mte_pkg::SLOT_W-1:0];
      r.expired   = expired;
      r.is_active = active[i];
      r.remaining = ticks_left(i);
      r.count     = cnt[mte_pkg::CNT_W-1:0];
      r.last      = last_flag;
      return r;
    endfunction

    function void note_request(mte_pkg::mode_t mode, logic [mte_pkg::SLOT_W-1:0] slot,
                               logic [mte_pkg::PERIOD_W-1:0] per, logic rel);
      int                           hits [$];
      int                           s;
      int                           cnt;
      logic                         bad;
      logic [mte_pkg::PERIOD_W-1:0] d;
      requests++;
      if (mode == mte_pkg::MODE_TICK) begin
        ticks++;
        now = now + mte_pkg::PERIOD_W'(1);
        for (int i = 0; i < SLOTS; i++) begin
          d = now - expiry[i];
          if (active[i] && !d[mte_pkg::PERIOD_W-1]) begin
            active[i] = 1'b0;
            if (reload[i]) arm(i);
            hits.push_back(i);
          end
        end
        cnt = active_total();
        foreach (hits[k])
          due.push_back(make_result(1'b0, hits[k], 1'b1, k == hits.size() - 1, cnt));
        expiries += hits.size();
        if (hits.size() > max_burst) max_burst = hits.size();
        return;
      end
      s   = int'(slot);
      bad = 1'b0;
      case (mode)
        mte_pkg::MODE_CONFIG: begin
          if (per == '0) begin
            bad = 1'b1;
          end else begin
            active[s] = 1'b0;
            expiry[s] = '0;
            period[s] = per;
            reload[s] = rel;
          end
        end
        mte_pkg::MODE_START, mte_pkg::MODE_RESTART: begin
          arm(s);
        end
        mte_pkg::MODE_STOP: begin
          active[s] = 1'b0;
        end
        mte_pkg::MODE_CHG_PER: begin
          if (per == '0) begin
            bad = 1'b1;
          end else begin
            period[s] = per;
            if (active[s]) arm(s);
          end
        end
        mte_pkg::MODE_DELETE: begin
          active[s] = 1'b0;
          expiry[s] = '0;
          period[s] = '0;
          reload[s] = 1'b0;
        end
        default: begin
        end
      endcase
      due.push_back(make_result(bad, s, 1'b0, 1'b1, active_total()));
    endfunction

    task report(string what);
      $display("%0t ns: mismatch: %s", $time, what);
      errors++;
    endtask

    task check_field(logic [mte_pkg::SLOT_W-1:0] slot, string name, logic [31:0] got,
                     logic [31:0] want);
      if (got !== want)
        report($sformatf("slot %0d %s got 0x%0h, want 0x%0h", slot, name, got, want));
    endtask

    task check_result(timer_result_t got);
      timer_result_t want;
      results++;
      if (due.size() == 0) begin
        report($sformatf("result for slot %0d with nothing outstanding", got.slot));
        return;
      end
      want = due.pop_front();
      check_field(want.slot, "status", 32'(got.status), 32'(want.status));
      check_field(want.slot, "slot_out", 32'(got.slot), 32'(want.slot));
      check_field(want.slot, "expired", 32'(got.expired), 32'(want.expired));
      check_field(want.slot, "is_active", 32'(got.is_active), 32'(want.is_active));
      check_field(want.slot, "remaining", 32'(got.remaining), 32'(want.remaining));
      check_field(want.slot, "active_count", 32'(got.count), 32'(want.count));
      check_field(want.slot, "last", 32'(got.last), 32'(want.last));
    endtask
  endclass

  logic                         clk            = 1'b0;
  logic                         rst_n          = 1'b0;
  logic                         start          = 1'b0;
  logic                         busy;
  logic [mte_pkg::MODE_W-1:0]   in_mode        = '0;
  logic [mte_pkg::SLOT_W-1:0]   in_slot        = '0;
  logic [mte_pkg::PERIOD_W-1:0] in_period      = '0;
  logic                         in_auto_reload = 1'b0;
  logic                         out_strobe;
  logic                         out_status;
  logic [mte_pkg::SLOT_W-1:0]   out_slot_out;
  logic                         out_expired;
  logic                         out_is_active;
  logic [mte_pkg::REM_W-1:0]    out_remaining;
  logic [mte_pkg::CNT_W-1:0]    out_active_count;
  logic                         out_last;

  expiry_scoreboard sb;
  int               idle_pct = 0;
  int               idle_by_phase [4] = '{0, 71, 0, 20};

  always #4 clk = ~clk;

  multi_timer_expiry_engine i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_mode          (in_mode),
    .in_slot          (in_slot),
    .in_period        (in_period),
    .in_auto_reload   (in_auto_reload),
    .out_strobe       (out_strobe),
    .out_status       (out_status),
    .out_slot_out     (out_slot_out),
    .out_expired      (out_expired),
    .out_is_active    (out_is_active),
    .out_remaining    (out_remaining),
    .out_active_count (out_active_count),
    .out_last         (out_last)
  );

  always @(posedge clk) begin
    if (rst_n && out_strobe)
      sb.check_result({out_status, out_slot_out, out_expired, out_is_active, out_remaining,
                       out_active_count, out_last});
  end

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic issue(mte_pkg::mode_t mode, logic [mte_pkg::SLOT_W-1:0] slot,
                       logic [mte_pkg::PERIOD_W-1:0] per, logic rel);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start          <= 1'b1;
    in_mode        <= mode;
    in_slot        <= slot;
    in_period      <= per;
    in_auto_reload <= rel;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_request(mode, slot, per, rel);
    @(negedge clk);
  endtask

  // Mostly short periods so slots expire often; a few zero or full-range ones.
  function automatic logic [mte_pkg::PERIOD_W-1:0] pick_period();
    int r;
    r = $urandom_range(0, 99);
    if (r < 3) return '0;
    if (r < 70) return $urandom_range(1, 6);
    if (r < 85) return $urandom_range(7, 300);
    return $urandom;
  endfunction

  task automatic random_request();
    int                           r;
    mte_pkg::mode_t               mode;
    logic [mte_pkg::PERIOD_W-1:0] per;
    r = $urandom_range(0, 99);
    if (r < 40)      mode = mte_pkg::MODE_TICK;
    else if (r < 55) mode = mte_pkg::MODE_CONFIG;
    else if (r < 67) mode = mte_pkg::MODE_START;
    else if (r < 75) mode = mte_pkg::MODE_RESTART;
    else if (r < 81) mode = mte_pkg::MODE_STOP;
    else if (r < 87) mode = mte_pkg::MODE_CHG_PER;
    else if (r < 92) mode = mte_pkg::MODE_DELETE;
    else             mode = mte_pkg::MODE_QUERY;
    per = (mode == mte_pkg::MODE_CONFIG || mode == mte_pkg::MODE_CHG_PER) ?
          pick_period() : $urandom;
    issue(mode, mte_pkg::SLOT_W'($urandom_range(0, SLOTS - 1)), per,
          1'($urandom_range(0, 1)));
  endtask

  initial begin
    sb = new();
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed corner cases, back to back
    issue(mte_pkg::MODE_TICK,    4'd0,  32'd0,         1'b0);  // quiet tick
    issue(mte_pkg::MODE_QUERY,   4'd0,  32'd0,         1'b0);
    issue(mte_pkg::MODE_CONFIG,  4'd3,  32'd0,         1'b1);  // zero period rejected
    issue(mte_pkg::MODE_CHG_PER, 4'd3,  32'd0,         1'b0);
    issue(mte_pkg::MODE_STOP,    4'd3,  32'd0,         1'b0);  // already inactive
    issue(mte_pkg::MODE_CHG_PER, 4'd3,  32'd5,         1'b0);  // store period only
    issue(mte_pkg::MODE_CONFIG,  4'd15, 32'hFFFF_FFFF, 1'b1);
    issue(mte_pkg::MODE_START,   4'd15, 32'hFFFF_FFFF, 1'b1);
    issue(mte_pkg::MODE_CONFIG,  4'd15, 32'h8000_0000, 1'b0);  // stops the active slot
    issue(mte_pkg::MODE_RESTART, 4'd15, 32'h7FFF_FFFF, 1'b1);
    issue(mte_pkg::MODE_CONFIG,  4'd0,  32'd2,         1'b1);
    issue(mte_pkg::MODE_START,   4'd0,  32'd0,         1'b0);
    issue(mte_pkg::MODE_START,   4'd3,  32'd0,         1'b0);
    issue(mte_pkg::MODE_CHG_PER, 4'd0,  32'd3,         1'b0);  // re-arm while active
    for (int i = 4; i < 12; i++)
      issue(mte_pkg::MODE_START, i[mte_pkg::SLOT_W-1:0], 32'd0, 1'b0);  // never configured
    issue(mte_pkg::MODE_TICK,    4'd9,  32'd0,         1'b1);
    issue(mte_pkg::MODE_TICK,    4'd0,  32'd0,         1'b0);
    issue(mte_pkg::MODE_TICK,    4'd0,  32'd0,         1'b0);
    issue(mte_pkg::MODE_DELETE,  4'd15, 32'd0,         1'b0);
    issue(mte_pkg::MODE_QUERY,   4'd15, 32'd0,         1'b0);

    // the receiver cannot hold off results, so only the sender gap rate varies between phases
    foreach (idle_by_phase[p]) begin
      idle_pct = idle_by_phase[p];
      repeat (90) random_request();
    end
    start    <= 1'b0;
    idle_pct = 0;

    for (int n = 0; n < 4096 && sb.due.size() > 0; n++) @(posedge clk);
    repeat (SCAN_CYCLES + 8) @(posedge clk);
    if (sb.due.size() > 0)
      sb.report($sformatf("%0d results never arrived", sb.due.size()));

    $display("Covered %0d requests including %0d ticks; %0d results, %0d expiries",
             sb.requests, sb.ticks, sb.results, sb.expiries);
    $display("Largest expiry burst on one tick: %0d slots; %0d mismatches",
             sb.max_burst, sb.errors);
    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Timed out with %0d results outstanding", sb.due.size());
    $display("== FAIL ==");
    $finish;
  end

endmodule
